>>> hdl/ept_pkg.sv
package ept_pkg;

   localparam int unsigned GA_W   = 48;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned IDX_W  = 9;
   localparam int unsigned PERM_W = 3;

   // opcode of an input beat
   localparam logic [1:0] OP_TRANSLATE = 2'd0;
   localparam logic [1:0] OP_SET_PERM  = 2'd1;
   localparam logic [1:0] OP_READ_DATA = 2'd2;

   // kind of a result beat
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam int unsigned SUPERPAGE_BIT = 7;

   // walk level: idle or waiting for the entry of level one to four
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_L1,
      ST_L2,
      ST_L3,
      ST_L4
   } walk_state_type;

   // which result the datapath forms
   typedef enum logic [2:0] {
      RES_READ_ROOT,
      RES_READ_NEXT,
      RES_WRITE,
      RES_FAIL,
      RES_HIT_4K,
      RES_HIT_2M
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        load_out;
      res_sel_type sel;
      logic [1:0]  level;     // table level of the next read, 0 is the top
   } dp_cmd_type;

   typedef struct packed {
      logic access_set;
      logic superpage;
   } dp_status_type;

   // table index of a guest address at a level, 0 is the top
   function automatic logic [IDX_W-1:0] level_index(input logic [GA_W-1:0] ga,
                                                    input logic [1:0] level);
      logic [IDX_W-1:0] idx;
      case (level)
         2'd0:    idx = ga[47:39];
         2'd1:    idx = ga[38:30];
         2'd2:    idx = ga[29:21];
         default: idx = ga[20:12];
      endcase
      return idx;
   endfunction

endpackage

>>> hdl/ept_req_if.sv
interface ept_req_if;
   import ept_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [GA_W-1:0]   guest_addr;
   logic [PERM_W-1:0] permission;
   logic [WORD_W-1:0] read_data;

   modport source (output valid, output opcode, output guest_addr,
                   output permission, output read_data, input ready);
   modport sink (input valid, input opcode, input guest_addr,
                 input permission, input read_data, output ready);
endinterface

>>> hdl/ept_rsp_if.sv
interface ept_rsp_if;
   import ept_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [WORD_W-1:0] mem_addr;
   logic [WORD_W-1:0] write_data;
   logic [WORD_W-1:0] host_addr;
   logic              ok;

   modport source (output valid, output kind, output mem_addr, output write_data,
                   output host_addr, output ok, input ready);
   modport sink (input valid, input kind, input mem_addr, input write_data,
                 input host_addr, input ok, output ready);
endinterface

>>> hdl/ept_ctrl.sv
module ept_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_opcode,
   input  logic                   rsp_ready,
   input  ept_pkg::dp_status_type status,
   output logic                   req_ready,
   output logic                   rsp_valid,
   output ept_pkg::dp_cmd_type    cmd
);
   import ept_pkg::*;

   walk_state_type state_ff, state_in;
   logic           pending_set_ff, pending_set_in;
   logic           out_valid_ff, out_valid_in;
   logic           fire;
   logic           is_request;
   logic           busy;

   assign req_ready  = !out_valid_ff || rsp_ready;
   assign rsp_valid  = out_valid_ff;
   assign fire       = req_valid && req_ready;
   assign is_request = (req_opcode == OP_TRANSLATE) || (req_opcode == OP_SET_PERM);
   assign busy       = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pending_set_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pending_set_ff <= pending_set_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      pending_set_in = pending_set_ff;
      cmd.load_req   = 1'b0;
      cmd.load_out   = 1'b0;
      cmd.sel        = RES_FAIL;
      cmd.level      = 2'd0;

      if (fire) begin
         if (is_request) begin
            cmd.load_out = 1'b1;
            if (!busy) begin
               cmd.load_req   = 1'b1;
               pending_set_in = (req_opcode == OP_SET_PERM);
               state_in       = ST_L1;
               cmd.sel        = RES_READ_ROOT;
            end
         end else if (req_opcode == OP_READ_DATA) begin
            cmd.load_out = 1'b1;
            case (state_ff)
               ST_IDLE: begin
                  cmd.sel = RES_FAIL;
               end
               ST_L1, ST_L2: begin
                  if (status.access_set) begin
                     cmd.sel   = RES_READ_NEXT;
                     cmd.level = (state_ff == ST_L1) ? 2'd1 : 2'd2;
                     state_in  = (state_ff == ST_L1) ? ST_L2 : ST_L3;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               ST_L3: begin
                  if (status.superpage) begin
                     state_in = ST_IDLE;
                     if (pending_set_ff)         cmd.sel = RES_WRITE;
                     else if (status.access_set) cmd.sel = RES_HIT_2M;
                     else                        cmd.sel = RES_FAIL;
                  end else if (status.access_set) begin
                     cmd.sel   = RES_READ_NEXT;
                     cmd.level = 2'd3;
                     state_in  = ST_L4;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               ST_L4: begin
                  state_in = ST_IDLE;
                  if (pending_set_ff)         cmd.sel = RES_WRITE;
                  else if (status.access_set) cmd.sel = RES_HIT_4K;
                  else                        cmd.sel = RES_FAIL;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
      end

      if (cmd.load_out)  out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else               out_valid_in = out_valid_ff;
   end

   // a new walk starts only from idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> (state_ff == ST_IDLE))
      else $error("walk started while busy");

   // data arriving while idle leaves the walker idle
   a_idle_data: assert property (@(posedge clock) disable iff (reset)
      (fire && (req_opcode == OP_READ_DATA) && (state_ff == ST_IDLE))
      |=> (state_ff == ST_IDLE))
      else $error("stray data changed the walk");

   // the fourth-level entry always ends the walk
   a_l4_end: assert property (@(posedge clock) disable iff (reset)
      (fire && (req_opcode == OP_READ_DATA) && (state_ff == ST_L4))
      |=> (state_ff == ST_IDLE))
      else $error("walk went past level four");

   // no beat is taken while a result is stuck
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !cmd.load_out)
      else $error("result overwritten before delivery");

endmodule

>>> hdl/ept_dp.sv
module ept_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [ept_pkg::WORD_W-1:0]   csr_write_data,
   input  logic [ept_pkg::GA_W-1:0]     in_guest_addr,
   input  logic [ept_pkg::PERM_W-1:0]   in_permission,
   input  logic [ept_pkg::WORD_W-1:0]   in_read_data,
   input  ept_pkg::dp_cmd_type          cmd,
   output ept_pkg::dp_status_type       status,
   output logic [1:0]                   out_kind,
   output logic [ept_pkg::WORD_W-1:0]   out_mem_addr,
   output logic [ept_pkg::WORD_W-1:0]   out_write_data,
   output logic [ept_pkg::WORD_W-1:0]   out_host_addr,
   output logic                         out_ok
);
   import ept_pkg::*;

   logic [WORD_W-1:0] table_root_ff;
   logic [GA_W-1:0]   held_ga_ff, held_ga_in;
   logic [PERM_W-1:0] held_perm_ff, held_perm_in;
   logic [WORD_W-1:0] entry_addr_ff, entry_addr_in;
   logic [1:0]        kind_ff, kind_in;
   logic [WORD_W-1:0] mem_addr_ff, mem_addr_in;
   logic [WORD_W-1:0] wdata_ff, wdata_in;
   logic [WORD_W-1:0] haddr_ff, haddr_in;
   logic              ok_ff, ok_in;

   logic [IDX_W-1:0]  root_idx;
   logic [IDX_W-1:0]  next_idx;
   logic [WORD_W-1:0] root_addr;
   logic [WORD_W-1:0] next_addr;

   assign status.access_set = |in_read_data[PERM_W-1:0];
   assign status.superpage  = in_read_data[SUPERPAGE_BIT];

   assign root_idx  = level_index(in_guest_addr, 2'd0);
   assign next_idx  = level_index(held_ga_ff, cmd.level);
   assign root_addr = table_root_ff + {{(WORD_W-IDX_W-3){1'b0}}, root_idx, 3'b000};
   assign next_addr = {in_read_data[WORD_W-1:12], next_idx, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         table_root_ff <= '0;
      end else if (csr_write_en) begin
         table_root_ff <= csr_write_data;
      end
      held_ga_ff    <= held_ga_in;
      held_perm_ff  <= held_perm_in;
      entry_addr_ff <= entry_addr_in;
      kind_ff       <= kind_in;
      mem_addr_ff   <= mem_addr_in;
      wdata_ff      <= wdata_in;
      haddr_ff      <= haddr_in;
      ok_ff         <= ok_in;
   end

   always_comb begin
      held_ga_in    = held_ga_ff;
      held_perm_in  = held_perm_ff;
      entry_addr_in = entry_addr_ff;
      kind_in       = kind_ff;
      mem_addr_in   = mem_addr_ff;
      wdata_in      = wdata_ff;
      haddr_in      = haddr_ff;
      ok_in         = ok_ff;

      if (cmd.load_req) begin
         held_ga_in   = in_guest_addr;
         held_perm_in = in_permission;
      end

      if (cmd.load_out) begin
         kind_in     = KIND_DONE;
         mem_addr_in = '0;
         wdata_in    = '0;
         haddr_in    = '0;
         ok_in       = 1'b0;
         case (cmd.sel)
            RES_READ_ROOT: begin
               kind_in       = KIND_READ;
               mem_addr_in   = root_addr;
               entry_addr_in = root_addr;
            end
            RES_READ_NEXT: begin
               kind_in       = KIND_READ;
               mem_addr_in   = next_addr;
               entry_addr_in = next_addr;
            end
            RES_WRITE: begin
               kind_in     = KIND_WRITE;
               mem_addr_in = entry_addr_ff;
               wdata_in    = {in_read_data[WORD_W-1:PERM_W], held_perm_ff};
               ok_in       = 1'b1;
            end
            RES_HIT_4K: begin
               haddr_in = {in_read_data[WORD_W-1:12], held_ga_ff[11:0]};
               ok_in    = 1'b1;
            end
            RES_HIT_2M: begin
               haddr_in = {in_read_data[WORD_W-1:21], held_ga_ff[20:0]};
               ok_in    = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   assign out_kind       = kind_ff;
   assign out_mem_addr   = mem_addr_ff;
   assign out_write_data = wdata_ff;
   assign out_host_addr  = haddr_ff;
   assign out_ok         = ok_ff;

endmodule

>>> hdl/ept_page_walker_core.sv
// Four-level extended page table walker. A translate or set-permission
// request beat on req_chan starts a walk; the walker answers each beat with
// at most one rsp_chan beat: a memory read request for the next entry, a
// memory write of the rewritten leaf, or a finish with the host address and
// ok flag. Entry data read from memory comes back on req_chan as read-data
// beats. A request during a walk and data while idle each get a failed
// finish; opcode three is dropped silently. The result of a beat lands in a
// single output register, so one beat per cycle is taken as long as
// rsp_ready keeps that register draining; the longest path is the 64-bit
// add of table_root and the first index. Write table_root through
// csr_write_en/csr_write_data only while no walk is open.
module ept_page_walker_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [ept_pkg::WORD_W-1:0]   csr_write_data,
   ept_req_if.sink                      req_chan,
   ept_rsp_if.source                    rsp_chan
);
   import ept_pkg::*;

   dp_cmd_type    cmd;      // controller to datapath
   dp_status_type status;   // entry flags back to the controller

   // walk level, pending set-permission flag and output valid
   ept_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .rsp_ready  (rsp_chan.ready),
      .status     (status),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .cmd        (cmd)
   );

   // table root, held request, entry address and the result register
   ept_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .in_guest_addr  (req_chan.guest_addr),
      .in_permission  (req_chan.permission),
      .in_read_data   (req_chan.read_data),
      .cmd            (cmd),
      .status         (status),
      .out_kind       (rsp_chan.kind),
      .out_mem_addr   (rsp_chan.mem_addr),
      .out_write_data (rsp_chan.write_data),
      .out_host_addr  (rsp_chan.host_addr),
      .out_ok         (rsp_chan.ok)
   );

endmodule
